// ===== sv/nsf_pkg.sv =====
// nsf_pkg: shared types, constants and helpers of the nmea sentence framer
// no dependencies; imported by every module of the framer
package nsf_pkg;

  localparam int BUFFER_LENGTH = 128;

  // placement limits on the sentence position
  localparam logic [7:0] LIMIT_CHAR = 8'(BUFFER_LENGTH - 5);
  localparam logic [7:0] LIMIT_BIN  = 8'(BUFFER_LENGTH - 6);

  localparam logic [7:0] CHAR_STAR  = 8'h2a;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_TEXT  = 3'd1,
    CMD_SEP   = 3'd2,
    CMD_BIN   = 3'd3,
    CMD_END   = 3'd4
  } command_t;

  // characters caused by one item, waiting to be streamed out
  typedef struct packed {
    logic [1:0]      count;
    logic            is_end;
    logic            trunc;
    logic [2:0][7:0] chars;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h37 + {4'd0, nib};
    end
    return d;
  endfunction

endpackage

// ===== sv/nsf_cmd_if.sv =====
// nsf_cmd_if: command channel of the nmea sentence framer
// no dependencies
interface nsf_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// ===== sv/nsf_char_if.sv =====
// nsf_char_if: character channel of the nmea sentence framer
// no dependencies
interface nsf_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       sentence_last;
  logic       truncated;

  modport source (output valid, output out_char, output sentence_last, output truncated,
                  input ready);
  modport sink   (input valid, input out_char, input sentence_last, input truncated,
                  output ready);
endinterface

// ===== sv/nsf_front.sv =====
// nsf_front: accepts commands, keeps sentence state, builds character bundles
// depends on nsf_pkg and nsf_cmd_if
module nsf_front (
  input  logic            clk,
  input  logic            rst,
  nsf_cmd_if.sink         cmd,
  input  nsf_pkg::qstat_t qstat,
  output logic            push,
  output nsf_pkg::bundle_t bundle
);
  import nsf_pkg::*;

  logic [7:0] position, position_next;
  logic [7:0] running_xor, running_xor_next;
  logic       dropped_flag, dropped_flag_next;
  logic       accept;
  logic [7:0] hi_dig, lo_dig;

  assign cmd.ready = !qstat.full;
  assign accept    = cmd.valid && cmd.ready;
  assign hi_dig    = hex_digit(cmd.data_byte[7:4]);
  assign lo_dig    = hex_digit(cmd.data_byte[3:0]);

  always_comb begin
    position_next     = position;
    running_xor_next  = running_xor;
    dropped_flag_next = dropped_flag;
    bundle            = '0;
    case (command_t'(cmd.command))
      CMD_START: begin
        position_next     = 8'd1;
        running_xor_next  = '0;
        dropped_flag_next = 1'b0;
        bundle.count      = 2'd1;
        bundle.chars[0]   = cmd.data_byte;
      end
      CMD_TEXT, CMD_SEP: begin
        if (position < LIMIT_CHAR) begin
          bundle.count    = 2'd1;
          bundle.chars[0] = (command_t'(cmd.command) == CMD_SEP) ? CHAR_COMMA : cmd.data_byte;
          position_next   = position + 8'd1;
          if (position != 8'd0) begin
            running_xor_next = running_xor ^ bundle.chars[0];
          end
        end else begin
          dropped_flag_next = 1'b1;
        end
      end
      CMD_BIN: begin
        if (position < LIMIT_BIN) begin
          bundle.count     = 2'd2;
          bundle.chars[0]  = hi_dig;
          bundle.chars[1]  = lo_dig;
          position_next    = position + 8'd2;
          // leading digit stays out of the checksum at position zero
          running_xor_next = running_xor ^ lo_dig ^ ((position != 8'd0) ? hi_dig : 8'd0);
        end else begin
          dropped_flag_next = 1'b1;
        end
      end
      CMD_END: begin
        bundle.count      = 2'd3;
        bundle.is_end     = 1'b1;
        bundle.chars[0]   = CHAR_STAR;
        bundle.chars[1]   = hex_digit(running_xor[7:4]);
        bundle.chars[2]   = hex_digit(running_xor[3:0]);
        position_next     = '0;
        running_xor_next  = '0;
        dropped_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
    bundle.trunc = (command_t'(cmd.command) == CMD_END) ? dropped_flag : dropped_flag_next;
  end

  assign push = accept && (bundle.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      running_xor  <= '0;
      dropped_flag <= 1'b0;
    end else if (accept) begin
      position     <= position_next;
      running_xor  <= running_xor_next;
      dropped_flag <= dropped_flag_next;
    end
  end

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("bundle pushed into a full queue");

endmodule

// ===== sv/nsf_queue.sv =====
// nsf_queue: short bundle queue between the front and the back
// depends on nsf_pkg
module nsf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  nsf_pkg::bundle_t push_data,
  input  logic             pop,
  output nsf_pkg::bundle_t head,
  output nsf_pkg::qstat_t  qstat
);
  import nsf_pkg::*;

  bundle_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QPTR_W:0]     fill;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head        = entries[rd_ptr];
  assign qstat.full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from an empty queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue fill count out of range");

endmodule

// ===== sv/nsf_back.sv =====
// nsf_back: streams the characters of each queued bundle through an output register
// depends on nsf_pkg and nsf_char_if
module nsf_back (
  input  logic             clk,
  input  logic             rst,
  input  nsf_pkg::bundle_t head,
  input  nsf_pkg::qstat_t  qstat,
  output logic             pop,
  nsf_char_if.source       chars
);
  import nsf_pkg::*;

  logic [1:0] idx;
  logic       emit;
  logic       last_of_bundle;
  logic [7:0] cur_char;

  assign emit           = !qstat.empty && (!chars.valid || chars.ready);
  assign last_of_bundle = (idx == head.count - 2'd1);
  assign pop            = emit && last_of_bundle;

  always_comb begin
    case (idx)
      2'd0:    cur_char = head.chars[0];
      2'd1:    cur_char = head.chars[1];
      2'd2:    cur_char = head.chars[2];
      default: cur_char = head.chars[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
      idx         <= '0;
    end else begin
      if (emit) begin
        chars.valid <= 1'b1;
        idx         <= last_of_bundle ? 2'd0 : idx + 2'd1;
      end else if (chars.ready) begin
        chars.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      chars.out_char      <= cur_char;
      chars.sentence_last <= head.is_end && (idx == 2'd2);
      chars.truncated     <= head.trunc;
    end
  end

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    !qstat.empty |-> (head.count != 2'd0) && (idx < head.count))
    else $error("character index beyond the queued bundle");

  a_last_after_emit: assert property (@(posedge clk) disable iff (rst)
    (emit && head.is_end && idx == 2'd2) |=> chars.valid && chars.sentence_last)
    else $error("final checksum digit not flagged");

endmodule

// ===== sv/nmea_sentence_framer.sv =====
// nmea_sentence_framer: top level of the nmea sentence framer
// depends on nsf_pkg, nsf_cmd_if, nsf_char_if, nsf_front, nsf_queue, nsf_back
//
//   channel  role  payload                                   handshake
//   cmd      sink  command[2:0], data_byte[7:0]              valid / ready
//   chars    src   out_char[7:0], sentence_last, truncated   valid / ready
//
// a command item is taken every cycle while the bundle queue has room
// characters leave one per cycle from the output register while chars is not stalled; binary bytes give
// two and end gives three, so the output port sets the sustained rate there
// first character of an item is registered in the bundle queue, then in the output register
// reset is synchronous (rst high) and clears position, checksum, drop flag,
// queue pointers and the output valid; stalls on chars back up through the queue
module nmea_sentence_framer (
  input  logic       clk,
  input  logic       rst,
  nsf_cmd_if.sink    cmd,
  nsf_char_if.source chars
);
  import nsf_pkg::*;

  // front to queue
  logic    push;
  bundle_t push_bundle;

  // queue to back
  logic    pop;
  bundle_t head;
  qstat_t  qstat;

  // front: sentence state and classification of each command item
  nsf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .qstat  (qstat),
    .push   (push),
    .bundle (push_bundle)
  );

  // short queue decoupling command intake from character output
  nsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_bundle),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // back: one character a cycle into the output register while chars is not stalled
  nsf_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .chars (chars)
  );

endmodule
